@@ hdl/tpa_pkg.sv @@
// Shared types and constants for the trapezoid profile axis planner.
// Used by the channel interfaces, the serial arithmetic units and the top level.
// No dependencies.
package tpa_pkg;

    // Field and register widths.
    localparam int POS_W      = 32;
    localparam int MS_W       = 8;
    localparam int ACCEL_W    = 24;
    localparam int SPEED_W    = 18;
    localparam int CMD_W      = 19;
    localparam int DIST_W     = 33;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    // Widths of the arithmetic path.
    localparam int PROD_W     = DIST_W + ACCEL_W;
    localparam int DIVIDEND_W = 32;
    localparam int RAMP_W     = 22;
    localparam int SUM_W      = RAMP_W + 1;
    localparam int RAD_W      = 58;
    localparam int ROOT_W     = RAD_W / 2;

    // Milliseconds per second, the divisor of the ramp step.
    localparam int MS_PER_S   = 1000;

    // Register indexes of the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_SPEED = 1'b1;

    // Register reset values.
    localparam logic [ACCEL_W-1:0] ACCEL_RESET     = 24'd20000;
    localparam logic [SPEED_W-1:0] TOP_SPEED_RESET = 18'd48000;

    // Limits of the elapsed time field.
    localparam logic [MS_W-1:0] MS_MIN = 8'd1;
    localparam logic [MS_W-1:0] MS_MAX = 8'd200;

    // Item operation codes.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_PLAN = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MUL_RAMP,
        ST_MUL_STOP,
        ST_SQRT,
        ST_FINISH
    } tpa_state_t;

    // Status of one serial arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

@@ hdl/tpa_if.sv @@
// Channel interfaces of the trapezoid profile axis planner: plan/tick items,
// result items and configuration writes. Depends on tpa_pkg for field widths.
interface tpa_item_if;
    logic                              valid;
    logic                              ready;
    logic                              op;
    logic signed [tpa_pkg::POS_W-1:0]  position;
    logic        [tpa_pkg::MS_W-1:0]   elapsed_ms;
    logic signed [tpa_pkg::POS_W-1:0]  approach_point;
    logic signed [tpa_pkg::POS_W-1:0]  final_point;

    modport source (output valid, op, position, elapsed_ms, approach_point, final_point,
                    input ready);
    modport sink (input valid, op, position, elapsed_ms, approach_point, final_point,
                  output ready);
endinterface

interface tpa_result_if;
    logic                              valid;
    logic                              ready;
    logic                              moving;
    logic signed [tpa_pkg::CMD_W-1:0]  speed_cmd;
    logic signed [tpa_pkg::POS_W-1:0]  leg_end;
    logic                              hold_now;

    modport source (output valid, moving, speed_cmd, leg_end, hold_now, input ready);
    modport sink (input valid, moving, speed_cmd, leg_end, hold_now, output ready);
endinterface

interface tpa_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [tpa_pkg::CFG_IDX_W-1:0]      index;
    logic [tpa_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/tpa_serial_mul.sv @@
// Shift-add multiplier that retires one multiplier bit per cycle.
// Depends on tpa_pkg for the unit status struct.
module tpa_serial_mul #(
    parameter int MCAND_W  = 33,
    parameter int MPLIER_W = 24,
    localparam int PROD_W  = MCAND_W + MPLIER_W,
    localparam int CNT_W   = $clog2(MPLIER_W + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [MCAND_W-1:0]    mcand,
    input  logic [MPLIER_W-1:0]   mplier,
    output logic [PROD_W-1:0]     product,
    output tpa_pkg::unit_stat_t   stat
);

    logic [MCAND_W-1:0]  mcand_reg;
    logic [MCAND_W-1:0]  hi_reg;
    logic [MPLIER_W-1:0] lo_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [MCAND_W:0]    sum;

    // The low product bits shift into the multiplier register as its bits retire.
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(MPLIER_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg <= mcand;
            hi_reg    <= '0;
            lo_reg    <= mplier;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[MCAND_W:1];
            lo_reg <= {sum[0], lo_reg[MPLIER_W-1:1]};
        end
    end

    assign product   = {hi_reg, lo_reg};
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ hdl/tpa_serial_sqrt.sv @@
// Restoring integer square root that produces one root bit per cycle.
// Depends on tpa_pkg for the unit status struct.
module tpa_serial_sqrt #(
    parameter int RAD_W   = 58,
    localparam int ROOT_W = RAD_W / 2,
    localparam int REM_W  = ROOT_W + 1,
    localparam int CNT_W  = $clog2(ROOT_W + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [RAD_W-1:0]     radicand,
    output logic [ROOT_W-1:0]    root,
    output tpa_pkg::unit_stat_t  stat
);

    logic [RAD_W-1:0]  x_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [REM_W+1:0]  part;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  part_diff;
    logic              fit;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;

    // Bring down the next two radicand bits and try the root bit as one.
    always_comb
    begin
        part      = {rem_reg, x_reg[RAD_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        part_diff = part - trial;
        fit       = (part >= trial);
        rem_next  = fit ? part_diff[REM_W-1:0] : part[REM_W-1:0];
        root_next = {root_reg[ROOT_W-2:0], fit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg    <= {x_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ hdl/tpa_const_div.sv @@
// Restoring divider by a fixed divisor that produces one quotient bit per cycle.
// Depends on tpa_pkg for the unit status struct.
module tpa_const_div #(
    parameter int DIVIDEND_W = 32,
    parameter int DIVISOR    = 1000,
    localparam int REM_W     = $clog2(DIVISOR),
    localparam int CNT_W     = $clog2(DIVIDEND_W + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    output logic [DIVIDEND_W-1:0] quotient,
    output tpa_pkg::unit_stat_t   stat
);

    localparam logic [REM_W:0] DIV_VAL = (REM_W + 1)'(DIVISOR);

    logic [DIVIDEND_W-1:0] n_reg;
    logic [REM_W-1:0]      r_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [REM_W:0]        part;
    logic [REM_W:0]        part_diff;
    logic                  fit;
    logic [REM_W-1:0]      r_next;

    // Quotient bits shift in at the bottom as the dividend bits leave the top.
    always_comb
    begin
        part      = {r_reg, n_reg[DIVIDEND_W-1]};
        part_diff = part - DIV_VAL;
        fit       = (part >= DIV_VAL);
        r_next    = fit ? part_diff[REM_W-1:0] : part[REM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg <= dividend;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            n_reg <= {n_reg[DIVIDEND_W-2:0], fit};
            r_reg <= r_next;
        end
    end

    assign quotient  = n_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ hdl/trapezoid_profile_axis.sv @@
// Top level of the single-axis trapezoid velocity planner.
// Depends on tpa_pkg, the channel interfaces in tpa_if.sv, tpa_serial_mul,
// tpa_const_div and tpa_serial_sqrt.
//
// Usage. Items arrive on the item channel and each one yields exactly one
// transfer on the result channel. A plan item (op set) loads a two-leg move,
// an approach point and a final point. Its result comes through the DECIDE and
// FINISH states; the next item is taken when the block is back in IDLE. A
// control tick (op clear) either ends a leg, reports an idle axis, or computes
// a new speed. The speed step is floor(acceleration * ms / 1000) and the
// stopping limit is floor(sqrt(2 * acceleration * distance)); both run on
// bit-serial units, so a driving tick stays in work until they are through.
// The chain that sets its time is the two 24-step shift-add products
// followed by the 29-step square root; the divide by 1000 runs alongside.
// Ticks that arrive or find the axis idle go from DECIDE straight to
// FINISH, like plans.
// The block handles one item at a time: item.ready is high only while no item
// is in work.
// The configuration channel is always ready; register 0 is the acceleration
// and register 1 the top speed. Write them only while no item is in work.
// Reset clears the axis state (idle, first leg, zero points and speed) and
// loads the register defaults. When the receiver stalls, the result holds in
// the output register and the next finished item waits until it is taken.
module trapezoid_profile_axis (
    input  logic          clk,
    input  logic          rst_n,
    tpa_cfg_if.sink       cfg,
    tpa_item_if.sink      item,
    tpa_result_if.source  result
);

    localparam int POS_W   = tpa_pkg::POS_W;
    localparam int DIST_W  = tpa_pkg::DIST_W;
    localparam int ACCEL_W = tpa_pkg::ACCEL_W;
    localparam int SPEED_W = tpa_pkg::SPEED_W;
    localparam int CMD_W   = tpa_pkg::CMD_W;
    localparam int MS_W    = tpa_pkg::MS_W;
    localparam int PROD_W  = tpa_pkg::PROD_W;
    localparam int DVD_W   = tpa_pkg::DIVIDEND_W;
    localparam int RAMP_W  = tpa_pkg::RAMP_W;
    localparam int SUM_W   = tpa_pkg::SUM_W;
    localparam int RAD_W   = tpa_pkg::RAD_W;
    localparam int ROOT_W  = tpa_pkg::ROOT_W;

    tpa_pkg::tpa_state_t state_reg;
    tpa_pkg::tpa_state_t state_next;

    // Configuration registers.
    logic [ACCEL_W-1:0] accel_reg;
    logic [SPEED_W-1:0] top_speed_reg;

    // Axis state.
    logic               active_reg;
    logic               second_leg_reg;
    logic [POS_W-1:0]   via_reg;
    logic [POS_W-1:0]   goal_reg;
    logic [SPEED_W-1:0] cur_speed_reg;

    // Captured item.
    logic               op_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [MS_W-1:0]    ms_reg;
    logic [POS_W-1:0]   ap_reg;
    logic [POS_W-1:0]   fp_reg;

    // Staged result of the item in work.
    logic [DIST_W-1:0]  dist_reg;
    logic               neg_reg;
    logic               res_moving_reg;
    logic [POS_W-1:0]   res_leg_reg;
    logic               res_hold_reg;
    logic               res_drive_reg;

    // Output register.
    logic               out_valid_reg;
    logic               out_moving_reg;
    logic [CMD_W-1:0]   out_speed_reg;
    logic [POS_W-1:0]   out_leg_reg;
    logic               out_hold_reg;

    // Decision logic of the captured item.
    logic [POS_W-1:0]   cur_leg;
    logic [POS_W-1:0]   sub_b_src;
    logic [DIST_W-1:0]  sub_a;
    logic [DIST_W-1:0]  sub_b;
    logic               plan_active;
    logic               plan_second;
    logic               plan_keep;
    logic               tick_switch;
    logic [DIST_W-1:0]  tick_rem;
    logic [POS_W-1:0]   tick_leg;
    logic               tick_arrive;
    logic               tick_drive;
    logic [DIST_W-1:0]  tick_dist;
    logic [MS_W-1:0]    ms_sat;
    logic               decide_drive;

    // Serial unit connections.
    logic                 mul_start;
    logic [DIST_W-1:0]    mul_mcand;
    logic [ACCEL_W-1:0]   mul_mplier;
    logic [PROD_W-1:0]    mul_prod;
    tpa_pkg::unit_stat_t  mul_stat;
    logic                 div_start;
    logic [DVD_W-1:0]     div_quot;
    tpa_pkg::unit_stat_t  div_stat;
    logic                 sqrt_start;
    logic [RAD_W-1:0]     sqrt_rad;
    logic [ROOT_W-1:0]    sqrt_root;
    tpa_pkg::unit_stat_t  sqrt_stat;

    // Speed clamp chain.
    logic [SUM_W-1:0]   v_sum;
    logic [SPEED_W-1:0] v_top;
    logic [SPEED_W-1:0] v_stop;
    logic [SPEED_W-1:0] v_next;
    logic [CMD_W-1:0]   cmd_next;
    logic               finish_go;

    // The configuration port never pushes back.
    assign cfg.ready = 1'b1;

    // ------------------------------------------------------------------
    // Decision on the captured item. Both differences are exact 33-bit values.
    // A plan compares the old leg with the new approach point; a tick needs the
    // current leg and, in case the approach leg ends now, the final point.
    // ------------------------------------------------------------------
    always_comb
    begin
        cur_leg   = second_leg_reg ? goal_reg : via_reg;
        sub_b_src = (op_reg == tpa_pkg::OP_PLAN) ? ap_reg : goal_reg;
        sub_a     = {cur_leg[POS_W-1], cur_leg} - {pos_reg[POS_W-1], pos_reg};
        sub_b     = {sub_b_src[POS_W-1], sub_b_src} - {pos_reg[POS_W-1], pos_reg};

        // When both points match, the second leg starts at once and its end is
        // the approach point as well, so the new leg end is always the latter.
        plan_active = (ap_reg != pos_reg) || (fp_reg != pos_reg);
        plan_second = (ap_reg == fp_reg);
        plan_keep   = active_reg && (sub_a != '0) && (sub_b != '0)
                      && (sub_a[DIST_W-1] == sub_b[DIST_W-1]);

        tick_switch = active_reg && (sub_a == '0) && !second_leg_reg;
        tick_rem    = tick_switch ? sub_b : sub_a;
        tick_leg    = tick_switch ? goal_reg : cur_leg;
        tick_arrive = active_reg && (tick_rem == '0);
        tick_drive  = active_reg && !tick_arrive;
        tick_dist   = tick_rem[DIST_W-1] ? (~tick_rem + DIST_W'(1)) : tick_rem;

        if (ms_reg < tpa_pkg::MS_MIN)
        begin
            ms_sat = tpa_pkg::MS_MIN;
        end
        else if (ms_reg > tpa_pkg::MS_MAX)
        begin
            ms_sat = tpa_pkg::MS_MAX;
        end
        else
        begin
            ms_sat = ms_reg;
        end

        decide_drive = (op_reg == tpa_pkg::OP_TICK) && tick_drive;
    end

    // ------------------------------------------------------------------
    // New speed: ramp from the current speed, then clamp to the top speed,
    // to the stopping limit and to at least one microstep per second.
    // ------------------------------------------------------------------
    always_comb
    begin
        v_sum  = SUM_W'(cur_speed_reg) + SUM_W'(div_quot[RAMP_W-1:0]);
        v_top  = (v_sum > SUM_W'(top_speed_reg)) ? top_speed_reg : v_sum[SPEED_W-1:0];
        v_stop = (ROOT_W'(v_top) > sqrt_root) ? sqrt_root[SPEED_W-1:0] : v_top;
        v_next = (v_stop == '0) ? SPEED_W'(1) : v_stop;
        cmd_next = neg_reg ? (~CMD_W'(v_next) + CMD_W'(1)) : CMD_W'(v_next);
    end

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tpa_pkg::ST_IDLE:
            begin
                if (item.valid)
                begin
                    state_next = tpa_pkg::ST_DECIDE;
                end
            end
            tpa_pkg::ST_DECIDE:
            begin
                state_next = decide_drive ? tpa_pkg::ST_MUL_RAMP : tpa_pkg::ST_FINISH;
            end
            tpa_pkg::ST_MUL_RAMP:
            begin
                if (mul_stat.done)
                begin
                    state_next = tpa_pkg::ST_MUL_STOP;
                end
            end
            tpa_pkg::ST_MUL_STOP:
            begin
                if (mul_stat.done)
                begin
                    state_next = tpa_pkg::ST_SQRT;
                end
            end
            tpa_pkg::ST_SQRT:
            begin
                if (sqrt_stat.done)
                begin
                    state_next = tpa_pkg::ST_FINISH;
                end
            end
            tpa_pkg::ST_FINISH:
            begin
                if (finish_go)
                begin
                    state_next = tpa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tpa_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs. The first product is acceleration times the
    // saturated milliseconds, the second acceleration times the distance.
    // The divide by 1000 starts on the first product and overlaps the rest.
    // ------------------------------------------------------------------
    always_comb
    begin
        item.ready = 1'b0;
        mul_start  = 1'b0;
        mul_mcand  = dist_reg;
        mul_mplier = accel_reg;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        finish_go  = 1'b0;
        case (state_reg)
            tpa_pkg::ST_IDLE:
            begin
                item.ready = 1'b1;
            end
            tpa_pkg::ST_DECIDE:
            begin
                mul_start  = decide_drive;
                mul_mcand  = DIST_W'(accel_reg);
                mul_mplier = ACCEL_W'(ms_sat);
            end
            tpa_pkg::ST_MUL_RAMP:
            begin
                mul_start = mul_stat.done;
                div_start = mul_stat.done;
            end
            tpa_pkg::ST_MUL_STOP:
            begin
                sqrt_start = mul_stat.done;
            end
            tpa_pkg::ST_SQRT:
            begin
                sqrt_start = 1'b0;
            end
            tpa_pkg::ST_FINISH:
            begin
                finish_go = !div_stat.busy && (!out_valid_reg || result.ready);
            end
            default:
            begin
                item.ready = 1'b0;
            end
        endcase
    end

    assign sqrt_rad = {1'b0, mul_prod[PROD_W-2:0], 1'b0};

    tpa_serial_mul #(
        .MCAND_W  (DIST_W),
        .MPLIER_W (ACCEL_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .product (mul_prod),
        .stat    (mul_stat)
    );

    tpa_const_div #(
        .DIVIDEND_W (DVD_W),
        .DIVISOR    (tpa_pkg::MS_PER_S)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_prod[DVD_W-1:0]),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    tpa_serial_sqrt #(
        .RAD_W (RAD_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_rad),
        .root     (sqrt_root),
        .stat     (sqrt_stat)
    );

    // ------------------------------------------------------------------
    // Control registers: state, configuration, axis state, output valid.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tpa_pkg::ST_IDLE;
            accel_reg      <= tpa_pkg::ACCEL_RESET;
            top_speed_reg  <= tpa_pkg::TOP_SPEED_RESET;
            active_reg     <= 1'b0;
            second_leg_reg <= 1'b0;
            via_reg        <= '0;
            goal_reg       <= '0;
            cur_speed_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    tpa_pkg::REG_ACCEL:     accel_reg     <= cfg.data[ACCEL_W-1:0];
                    tpa_pkg::REG_TOP_SPEED: top_speed_reg <= cfg.data[SPEED_W-1:0];
                    default:                accel_reg     <= accel_reg;
                endcase
            end

            if (state_reg == tpa_pkg::ST_DECIDE)
            begin
                if (op_reg == tpa_pkg::OP_PLAN)
                begin
                    via_reg        <= ap_reg;
                    goal_reg       <= fp_reg;
                    second_leg_reg <= plan_second;
                    active_reg     <= plan_active;
                    if (!plan_keep)
                    begin
                        cur_speed_reg <= '0;
                    end
                end
                else
                begin
                    // Reaching the approach point starts the final leg from rest.
                    if (tick_switch)
                    begin
                        second_leg_reg <= 1'b1;
                        cur_speed_reg  <= '0;
                    end
                    if (tick_arrive)
                    begin
                        active_reg <= 1'b0;
                    end
                end
            end

            if (finish_go && res_drive_reg)
            begin
                cur_speed_reg <= v_next;
            end

            if (finish_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers: captured item, staged result, output fields.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            op_reg  <= item.op;
            pos_reg <= item.position;
            ms_reg  <= item.elapsed_ms;
            ap_reg  <= item.approach_point;
            fp_reg  <= item.final_point;
        end

        if (state_reg == tpa_pkg::ST_DECIDE)
        begin
            dist_reg <= tick_dist;
            neg_reg  <= tick_rem[DIST_W-1];
            if (op_reg == tpa_pkg::OP_PLAN)
            begin
                res_moving_reg <= plan_active;
                res_leg_reg    <= ap_reg;
                res_hold_reg   <= 1'b0;
                res_drive_reg  <= 1'b0;
            end
            else
            begin
                res_moving_reg <= tick_drive;
                res_leg_reg    <= tick_leg;
                res_hold_reg   <= tick_arrive;
                res_drive_reg  <= tick_drive;
            end
        end

        if (finish_go)
        begin
            out_moving_reg <= res_moving_reg;
            out_leg_reg    <= res_leg_reg;
            out_hold_reg   <= res_hold_reg;
            out_speed_reg  <= res_drive_reg ? cmd_next : '0;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.moving    = out_moving_reg;
    assign result.speed_cmd = out_speed_reg;
    assign result.leg_end   = out_leg_reg;
    assign result.hold_now  = out_hold_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // An arrival never drives the motor and leaves the axis stopped.
    a_hold_stops: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.hold_now |-> !result.moving && (result.speed_cmd == '0))
        else $error("hold result with motion");

    // A driving tick always commands a nonzero speed.
    a_drive_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        finish_go && res_drive_reg |=> (result.speed_cmd != '0))
        else $error("driving tick with zero speed");

    // The stored speed never passes the ceiling, or one when the ceiling is zero.
    a_speed_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        finish_go && res_drive_reg
        |=> (cur_speed_reg <= top_speed_reg) || (cur_speed_reg == SPEED_W'(1)))
        else $error("speed above ceiling");

    // The product and the root unit never work at the same time.
    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_stat.busy && sqrt_stat.busy))
        else $error("multiplier and square root overlap");

    // A new item is taken only when every serial unit has finished.
    a_ready_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        item.ready |-> !mul_stat.busy && !sqrt_stat.busy && !div_stat.busy)
        else $error("item taken while a unit is busy");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the single-axis trapezoid velocity planner.
// Depends on tpa_pkg, the channel interfaces in tpa_if.sv and trapezoid_profile_axis.
`timescale 1ns / 100ps

module testbench;

    localparam int          POS_W      = tpa_pkg::POS_W;
    localparam int          MS_W       = tpa_pkg::MS_W;
    localparam int          ACCEL_W    = tpa_pkg::ACCEL_W;
    localparam int          SPEED_W    = tpa_pkg::SPEED_W;
    localparam int          CMD_W      = tpa_pkg::CMD_W;
    localparam int          CFG_IDX_W  = tpa_pkg::CFG_IDX_W;
    localparam int          CFG_DATA_W = tpa_pkg::CFG_DATA_W;

    localparam int          HALF_PERIOD = 6;
    localparam int          RESET_CYCLES = 5;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    // Long enough for a driving tick still in flight to finish.
    localparam int          SETTLE_CYCLES = 100;
    localparam int          MAX_PRINTED = 200;

    // One result transfer as the planner should produce it.
    typedef struct {
        logic                     moving;
        logic signed [CMD_W-1:0]  speed_cmd;
        logic signed [POS_W-1:0]  leg_end;
        logic                     hold_now;
    } motion_t;

    logic clk;
    logic rst_n;

    tpa_item_if   item_ch ();
    tpa_result_if result_ch ();
    tpa_cfg_if    cfg_ch ();

    trapezoid_profile_axis u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .item   (item_ch),
        .result (result_ch)
    );

    // Shadow copy of the planner registers and axis state, updated at the
    // moment each transfer is accepted so it always matches the block.
    logic [ACCEL_W-1:0]      acc_reg = tpa_pkg::ACCEL_RESET;
    logic [SPEED_W-1:0]      top_reg = tpa_pkg::TOP_SPEED_RESET;
    logic                    ax_active = 1'b0;
    logic                    ax_second = 1'b0;
    logic signed [POS_W-1:0] ax_via = '0;
    logic signed [POS_W-1:0] ax_goal = '0;
    logic [SPEED_W-1:0]      ax_speed = '0;

    // Expected result transfers, oldest first.
    motion_t planner_out_q[$];

    // Where the stimulus believes the axis currently is.
    logic signed [POS_W-1:0] axis_pos = '0;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_request = 0;
    int          error_count = 0;
    int          result_count = 0;
    int unsigned cycle_count = 0;

    // Free-running clock.
    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Every mismatch goes through here. Printing is capped so that a badly
    // broken design cannot flood the log, but every error is counted.
    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    function automatic int dir_of(input longint d);
        return (d > 0) ? 1 : ((d < 0) ? -1 : 0);
    endfunction

    function automatic longint current_leg_end();
        return ax_second ? longint'(ax_goal) : longint'(ax_via);
    endfunction

    // Exact integer square root, floor, by building the root one bit at a
    // time from the top. The radicand never exceeds 2^58.
    function automatic longint floor_sqrt(input longint x);
        longint root;
        longint trial;
        root = 0;
        for (int b = 29; b >= 0; b--)
        begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= x)
                root = trial;
        end
        return root;
    endfunction

    // Predicts the result of one accepted item and advances the shadow state.
    // All distances are held in 64 bits, so no difference of two positions
    // ever wraps.
    function automatic motion_t step_planner(input logic op,
                                             input logic signed [POS_W-1:0] pos,
                                             input logic [MS_W-1:0] ms,
                                             input logic signed [POS_W-1:0] ap,
                                             input logic signed [POS_W-1:0] fp);
        motion_t r;
        longint  p;
        longint  leg;
        longint  rem;
        longint  span;
        longint  vstop;
        longint  v;
        longint  msv;
        int      old_dir;
        int      new_dir;

        p = longint'(pos);
        r.moving = 1'b0;
        r.speed_cmd = '0;
        r.hold_now = 1'b0;
        r.leg_end = POS_W'(current_leg_end());

        if (op == tpa_pkg::OP_PLAN)
        begin
            // The running speed survives a new plan only when the axis was
            // moving and keeps heading the same way.
            old_dir = ax_active ? dir_of(current_leg_end() - p) : 0;
            ax_via = ap;
            ax_goal = fp;
            ax_second = (ap == fp);
            ax_active = (ap != pos) || (fp != pos);
            new_dir = dir_of(current_leg_end() - p);
            if (old_dir == 0 || new_dir != old_dir)
                ax_speed = '0;
            r.moving = ax_active;
            r.leg_end = POS_W'(current_leg_end());
            return r;
        end

        if (!ax_active)
            return r;

        leg = current_leg_end();
        rem = leg - p;
        if (rem == 0)
        begin
            // Reaching the approach point starts the final leg from rest.
            if (!ax_second)
            begin
                ax_second = 1'b1;
                ax_speed = '0;
                leg = longint'(ax_goal);
                rem = leg - p;
            end
            if (rem == 0)
            begin
                ax_active = 1'b0;
                r.leg_end = POS_W'(leg);
                r.hold_now = 1'b1;
                return r;
            end
        end

        msv = longint'(ms);
        if (msv < longint'(tpa_pkg::MS_MIN))
            msv = longint'(tpa_pkg::MS_MIN);
        if (msv > longint'(tpa_pkg::MS_MAX))
            msv = longint'(tpa_pkg::MS_MAX);
        span = (rem < 0) ? -rem : rem;
        vstop = floor_sqrt(2 * longint'(acc_reg) * span);
        v = longint'(ax_speed) + (longint'(acc_reg) * msv) / tpa_pkg::MS_PER_S;
        if (v > longint'(top_reg))
            v = longint'(top_reg);
        if (v > vstop)
            v = vstop;
        if (v < 1)
            v = 1;
        ax_speed = SPEED_W'(v);
        r.moving = 1'b1;
        r.speed_cmd = CMD_W'((rem < 0) ? -v : v);
        r.leg_end = POS_W'(leg);
        return r;
    endfunction

    // Offers one item, after a random idle gap, and holds it until the block
    // takes the transfer. The prediction is made at the accepting edge. The
    // task returns on the following falling edge with valid still high, so a
    // back-to-back item keeps valid up without a glitch.
    task automatic send_item(input logic op,
                             input logic signed [POS_W-1:0] pos,
                             input logic [MS_W-1:0] ms,
                             input logic signed [POS_W-1:0] ap,
                             input logic signed [POS_W-1:0] fp);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 60)
            gap++;
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid          <= 1'b1;
        item_ch.op             <= op;
        item_ch.position       <= pos;
        item_ch.elapsed_ms     <= ms;
        item_ch.approach_point <= ap;
        item_ch.final_point    <= fp;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        planner_out_q.push_back(step_planner(op, pos, ms, ap, fp));
        @(negedge clk);
    endtask

    // Drops valid and waits until every expected result has been taken.
    // The block is idle afterwards, since each item yields exactly one result.
    task automatic wait_for_responses();
        item_ch.valid <= 1'b0;
        @(negedge clk);
        while (planner_out_q.size() != 0)
            @(negedge clk);
    endtask

    // One write on the configuration channel. Call only while idle.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (idx == tpa_pkg::REG_ACCEL)
            acc_reg = data[ACCEL_W-1:0];
        else
            top_reg = data[SPEED_W-1:0];
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_registers(input logic [CFG_DATA_W-1:0] accel,
                                  input logic [CFG_DATA_W-1:0] vmax);
        write_register(tpa_pkg::REG_ACCEL, accel);
        write_register(tpa_pkg::REG_TOP_SPEED, vmax);
    endtask

    // Move lengths: mostly short so that moves finish in a few ticks, some
    // medium, and a few across the whole position range.
    function automatic longint pick_travel();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return longint'($urandom_range(0, 2000));
        if (r < 95)
            return longint'($urandom_range(0, 200000));
        return longint'($urandom);
    endfunction

    // Elapsed time mostly in its nominal range; now and then any 8-bit value,
    // which exercises the saturation at both ends.
    function automatic logic [MS_W-1:0] pick_ms();
        if ($urandom_range(9) == 0)
            return MS_W'($urandom_range(255));
        return MS_W'($urandom_range(1, 200));
    endfunction

    // A plan from where the axis stands. With keep_dir set and the axis
    // moving, the new move heads the same way, keeping the speed unless ap stays at base.
    task automatic send_plan(input bit keep_dir);
        longint base;
        longint ap;
        longint fp;
        int     dir;
        int     r;
        base = longint'(axis_pos);
        dir = (keep_dir && ax_active) ? dir_of(current_leg_end() - base) : 0;
        if (dir == 0)
            dir = ($urandom_range(1) != 0) ? 1 : -1;
        ap = base + dir * pick_travel();
        r = $urandom_range(99);
        if (r < 20)
            fp = ap;
        else if (r < 30)
        begin
            // Approach point right here: the first tick moves to the last leg.
            ap = base;
            fp = base + dir * pick_travel();
        end
        else
            fp = ap - dir * int'($urandom_range(1, 400));
        send_item(tpa_pkg::OP_PLAN, axis_pos, pick_ms(), POS_W'(ap), POS_W'(fp));
    endtask

    // A tick after the axis has moved part of the way to its leg end. Often
    // it lands exactly on the leg end, sometimes it overshoots a little.
    task automatic send_tick();
        longint rem;
        longint mag;
        longint step;
        int     r;
        rem = current_leg_end() - longint'(axis_pos);
        mag = (rem < 0) ? -rem : rem;
        r = $urandom_range(99);
        if (mag == 0 || r < 30)
            step = mag;
        else if (r < 35)
            step = mag + longint'($urandom_range(1, 50));
        else
            step = (mag * longint'($urandom_range(1, 90))) / 100;
        axis_pos = POS_W'(longint'(axis_pos) + ((rem < 0) ? -step : step));
        send_item(tpa_pkg::OP_TICK, axis_pos, pick_ms(), $urandom, $urandom);
    endtask

    // Mostly realistic plan-and-tick sequences, with some interrupting plans
    // and some completely random items mixed in.
    task automatic run_moves(input int count);
        int r;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(99);
            if (r < 8)
                send_item(1'($urandom_range(1)), $urandom, MS_W'($urandom_range(255)),
                          $urandom, $urandom);
            else if (r < 14 || !ax_active)
                send_plan(r < 11);
            else
                send_tick();
        end
    endtask

    // Hand-picked items at the default registers: idle ticks, both legs,
    // arrival with hold, plans that keep or drop the speed, saturated
    // elapsed times, overshoot and the position extremes.
    task automatic test_directed_cases();
        send_item(tpa_pkg::OP_TICK, 32'sd12345, 8'd50, '0, '0);
        send_item(tpa_pkg::OP_PLAN, 32'sd0, 8'd50, 32'sd5000, 32'sd4900);
        send_item(tpa_pkg::OP_TICK, 32'sd0, tpa_pkg::MS_MAX, '0, '0);
        send_item(tpa_pkg::OP_TICK, 32'sd2000, 8'd0, '0, '0);
        send_item(tpa_pkg::OP_TICK, 32'sd4000, 8'd255, '0, '0);
        send_item(tpa_pkg::OP_TICK, 32'sd5000, 8'd20, '0, '0);
        send_item(tpa_pkg::OP_TICK, 32'sd4900, tpa_pkg::MS_MIN, '0, '0);
        send_item(tpa_pkg::OP_TICK, 32'sd4900, 8'd10, '0, '0);
        send_item(tpa_pkg::OP_PLAN, 32'sd4900, 8'd10, 32'sd4900, 32'sd4900);
        send_item(tpa_pkg::OP_TICK, 32'sd4900, 8'd10, '0, '0);
        send_item(tpa_pkg::OP_PLAN, 32'sd0, 8'd10, 32'sd0, -32'sd3000);
        send_item(tpa_pkg::OP_TICK, 32'sd0, 8'd100, '0, '0);
        send_item(tpa_pkg::OP_PLAN, -32'sd100, 8'd10, -32'sd2000, -32'sd2000);
        send_item(tpa_pkg::OP_TICK, -32'sd100, 8'd100, '0, '0);
        send_item(tpa_pkg::OP_PLAN, -32'sd200, 8'd10, 32'sd5000, 32'sd5000);
        send_item(tpa_pkg::OP_TICK, -32'sd200, 8'd100, '0, '0);
        send_item(tpa_pkg::OP_TICK, 32'sd5050, 8'd100, '0, '0);
        send_item(tpa_pkg::OP_PLAN, 32'h8000_0000, 8'd10, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(tpa_pkg::OP_TICK, 32'h8000_0000, tpa_pkg::MS_MAX, '0, '0);
        send_item(tpa_pkg::OP_TICK, 32'h7FFF_FFFF, tpa_pkg::MS_MAX, '0, '0);
        send_item(tpa_pkg::OP_PLAN, 32'h7FFF_FFFF, 8'd10, 32'h8000_0000, 32'h8000_0000);
        send_item(tpa_pkg::OP_TICK, 32'h7FFF_FFFF, tpa_pkg::MS_MAX, '0, '0);
        send_item(tpa_pkg::OP_TICK, 32'h8000_0000, tpa_pkg::MS_MAX, '0, '0);
        wait_for_responses();
    endtask

    // Register corners, including zero values and a top speed write with
    // bits above the register width set.
    task automatic test_register_extremes();
        send_idle_pct = 14;
        recv_stall_pct = 14;
        load_registers(24'd0, 24'd0);
        run_moves(40);
        wait_for_responses();
        load_registers(24'd1, 24'd1);
        run_moves(40);
        wait_for_responses();
        load_registers(24'hFF_FFFF, 24'hFF_FFFF);
        run_moves(40);
        wait_for_responses();
        load_registers(24'hFF_FFFF, 24'd1);
        run_moves(40);
        wait_for_responses();
        load_registers(24'd1, 24'd262143);
        run_moves(40);
        wait_for_responses();
        load_registers(24'd0, 24'd262143);
        run_moves(40);
        wait_for_responses();
    endtask

    // Random register settings under each idle pattern in turn: none, a
    // sparse sender, a slow receiver, and light idling on both sides.
    task automatic test_idle_phases();
        logic [CFG_DATA_W-1:0] accel;
        logic [CFG_DATA_W-1:0] vmax;
        int                    r;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 85;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 85;
                end
                default:
                begin
                    send_idle_pct = 14;
                    recv_stall_pct = 14;
                end
            endcase
            r = $urandom_range(99);
            if (r < 60)
                accel = CFG_DATA_W'($urandom_range(500, 200000));
            else if (r < 90)
                accel = CFG_DATA_W'($urandom_range(1, 24'hFF_FFFF));
            else
                accel = CFG_DATA_W'($urandom_range(0, 50));
            if ($urandom_range(99) < 60)
                vmax = CFG_DATA_W'($urandom_range(500, 262143));
            else
                vmax = CFG_DATA_W'($urandom_range(0, 24'hFF_FFFF));
            load_registers(accel, vmax);
            run_moves(250);
            wait_for_responses();
        end
    endtask

    // The receiver stops taking results for a long stretch while the sender
    // keeps offering items back to back, so the block has to stall its input.
    task automatic test_back_pressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        load_registers(tpa_pkg::ACCEL_RESET, tpa_pkg::TOP_SPEED_RESET);
        @(posedge clk);
        hold_request = 600;
        @(negedge clk);
        run_moves(40);
        send_idle_pct = 14;
        recv_stall_pct = 14;
        run_moves(160);
        wait_for_responses();
    endtask

    // Receiver side: random stalls, plus a hold-off counted down here when
    // a test asks for one.
    always @(negedge clk)
    begin : result_ready_drive
        int hold_left;
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker: every result transfer is matched, field by field,
    // against the oldest expectation.
    always @(posedge clk)
    begin
        motion_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            result_count++;
            if (planner_out_q.size() == 0)
                report_error($sformatf("result %0d arrived with nothing expected",
                                       result_count));
            else
            begin
                want = planner_out_q.pop_front();
                if (result_ch.moving !== want.moving)
                    report_error($sformatf("result %0d: moving %b, expected %b",
                                           result_count, result_ch.moving, want.moving));
                if (result_ch.speed_cmd !== want.speed_cmd)
                    report_error($sformatf("result %0d: speed_cmd %0d, expected %0d",
                                           result_count, result_ch.speed_cmd,
                                           want.speed_cmd));
                if (result_ch.leg_end !== want.leg_end)
                    report_error($sformatf("result %0d: leg_end %0d, expected %0d",
                                           result_count, result_ch.leg_end, want.leg_end));
                if (result_ch.hold_now !== want.hold_now)
                    report_error($sformatf("result %0d: hold_now %b, expected %b",
                                           result_count, result_ch.hold_now, want.hold_now));
            end
        end
    end

    // Main sequence: reset once, run the tests in turn, then let the block
    // settle and give the verdict.
    initial
    begin
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.op = tpa_pkg::OP_TICK;
        item_ch.position = '0;
        item_ch.elapsed_ms = '0;
        item_ch.approach_point = '0;
        item_ch.final_point = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = tpa_pkg::REG_ACCEL;
        cfg_ch.data = '0;
        result_ch.ready = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_register_extremes();
        test_idle_phases();
        test_back_pressure();

        wait_for_responses();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
